@@ rtl/sdcl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the seven-segment decoder for the swipe digit code lock.
// No dependencies; used by sdcl_core, the top level and the checker.

package sdcl_pkg;

    localparam int unsigned CountW   = 4;
    localparam int unsigned IdleW    = 8;
    localparam int unsigned SegW     = 7;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 16;

    localparam logic [CountW-1:0] MaxCount   = 4'd9;
    localparam logic [IdleW-1:0]  IdleSatMax = 8'hFF;

    localparam logic [CountW-1:0] FirstTargetReset  = 4'd3;
    localparam logic [CountW-1:0] SecondTargetReset = 4'd2;
    localparam logic [IdleW-1:0]  IdleLimitReset    = 8'd30;

    localparam logic [SegW-1:0] SegZero  = 7'h3F;
    localparam logic [SegW-1:0] SegBlank = 7'h00;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegFirstTarget  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSecondTarget = 2'd1;
    localparam logic [CfgIdxW-1:0] RegIdleLimit    = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_GOOD  = 2'd1,
        VERDICT_WRONG = 2'd2
    } t_verdict;

    typedef struct packed {
        logic emergency;
        logic sensor_two;
        logic sensor_one;
    } t_sample;

    typedef struct packed {
        logic [IdleW-1:0]  idle_limit;
        logic [CountW-1:0] second_target;
        logic [CountW-1:0] first_target;
    } t_cfg;

    typedef struct packed {
        logic            aborted;
        logic            entry_phase;
        t_verdict        verdict;
        logic [SegW-1:0] segments;
    } t_result;

    function automatic logic [SegW-1:0] seg_pattern(input logic [CountW-1:0] n);
        logic [SegW-1:0] p;
        begin
            case (n)
                4'd0:    p = 7'h3F;
                4'd1:    p = 7'h06;
                4'd2:    p = 7'h5B;
                4'd3:    p = 7'h4F;
                4'd4:    p = 7'h66;
                4'd5:    p = 7'h6D;
                4'd6:    p = 7'h7D;
                4'd7:    p = 7'h07;
                4'd8:    p = 7'h7F;
                4'd9:    p = 7'h6F;
                default: p = SegBlank;
            endcase
            return p;
        end
    endfunction

endpackage

@@ rtl/sdcl_core.sv @@
`timescale 1ns / 1ps
// Entry state and next-state logic of the swipe digit code lock.
// Depends on sdcl_pkg.

module sdcl_core import sdcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic              r_phase,    n_phase;
    logic              r_prev,     n_prev;
    logic              r_primed,   n_primed;
    logic [CountW-1:0] r_count,    n_count;
    logic [IdleW-1:0]  r_idle,     n_idle;
    logic [CountW-1:0] r_first,    n_first;
    logic [SegW-1:0]   r_display,  n_display;

    logic              level;
    logic [CountW:0]   count_inc;

    always_comb begin
        n_phase   = r_phase;
        n_prev    = r_prev;
        n_primed  = r_primed;
        n_count   = r_count;
        n_idle    = r_idle;
        n_first   = r_first;
        n_display = r_display;
        o_result  = '0;
        level     = r_phase ? i_sample.sensor_two : i_sample.sensor_one;
        count_inc = {1'b0, r_count} + 5'd1;

        if (i_sample.emergency) begin
            n_phase   = 1'b0;
            n_primed  = 1'b0;
            n_count   = '0;
            n_idle    = '0;
            n_first   = '0;
            n_display = SegZero;
            o_result.aborted = 1'b1;
        end else if (!r_primed) begin
            n_prev   = level;
            n_primed = 1'b1;
        end else begin
            // A falling edge on the active sensor is one swipe.
            if (!level && r_prev) begin
                n_count   = (count_inc > {1'b0, MaxCount}) ? MaxCount
                                                           : count_inc[CountW-1:0];
                n_display = seg_pattern(n_count);
                n_idle    = '0;
            end
            n_prev = level;
            if (n_idle != IdleSatMax) begin
                n_idle = n_idle + 8'd1;
            end
            if ((n_count != '0) && (n_idle >= i_cfg.idle_limit)) begin
                if (!r_phase) begin
                    n_first  = n_count;
                    n_phase  = 1'b1;
                    n_count  = '0;
                    n_idle   = '0;
                    n_primed = 1'b0;
                end else begin
                    o_result.verdict = ((r_first == i_cfg.first_target) &&
                                        (n_count == i_cfg.second_target))
                                       ? VERDICT_GOOD : VERDICT_WRONG;
                    n_phase   = 1'b0;
                    n_primed  = 1'b0;
                    n_count   = '0;
                    n_idle    = '0;
                    n_first   = '0;
                    n_display = SegZero;
                end
            end
        end

        o_result.segments    = n_display;
        o_result.entry_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_prev    <= 1'b0;
            r_primed  <= 1'b0;
            r_count   <= '0;
            r_idle    <= '0;
            r_first   <= '0;
            r_display <= SegZero;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_prev    <= n_prev;
            r_primed  <= n_primed;
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_first   <= n_first;
            r_display <= n_display;
        end
    end

endmodule

@@ rtl/swipe_digit_code_lock_top.sv @@
`timescale 1ns / 1ps
// Top level of the swipe digit code lock: stream ports, configuration registers,
// result register. Depends on sdcl_pkg and sdcl_core.

// Each input transaction is one sensor sample tick and yields exactly one output
// transaction the next cycle. The lock counts falling edges (lit to shadowed) of
// sensor one for the first digit and of sensor two for the second digit; a count
// saturates at nine. A digit closes once its count is nonzero and the idle ticks
// since the last swipe reach idle_limit. After the second digit the lock compares
// both digits with first_target and second_target and reports a verdict for one
// tick (1 correct, 2 wrong), then starts over. The first tick of every phase only
// samples the sensor. The emergency bit aborts the entry at once and shows zero.
// Throughput is one transaction per clock: the whole update is a single pass of
// short logic between the entry state and the result register, and the slave side
// stays ready while the result register is empty or being drained in the same
// cycle. Configuration writes are always accepted and take effect on the next
// tick; they should be issued only while no output transaction is pending.

module swipe_digit_code_lock_top import sdcl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Sample stream. tdata: [0] sensor_one, [1] sensor_two, [2] emergency, rest zero.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,
    // Result stream. tdata: [6:0] segments, [8:7] verdict, [9] entry_phase,
    // [10] aborted, rest zero.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,
    // Configuration writes.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_sample sample;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign sample        = s_axis_tdata[2:0];

    // Writes to an index beyond the register list are taken and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_target  <= FirstTargetReset;
            r_cfg.second_target <= SecondTargetReset;
            r_cfg.idle_limit    <= IdleLimitReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegFirstTarget:  r_cfg.first_target  <= i_cfg_data[CountW-1:0];
                RegSecondTarget: r_cfg.second_target <= i_cfg_data[CountW-1:0];
                RegIdleLimit:    r_cfg.idle_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_sample (sample),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // The result register holds a finished transaction until the master side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result};

endmodule

@@ rtl/sdcl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the swipe digit code lock, bound to the top level.
// Depends on sdcl_pkg.

module sdcl_checker import sdcl_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A verdict returns the lock to the first digit with the display at zero.
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[8:7] != VERDICT_NONE) |->
        !m_axis_tdata[9] && (m_axis_tdata[6:0] == SegZero) && !m_axis_tdata[10])
        else $error("verdict with wrong phase or display");

    // An abort clears the entry and never carries a verdict.
    a_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
        !m_axis_tdata[9] && (m_axis_tdata[6:0] == SegZero) &&
        (m_axis_tdata[8:7] == VERDICT_NONE))
        else $error("abort did not clear the entry");

    // The unused verdict code and padding bits never appear.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:7] != 2'd3) && (m_axis_tdata[15:11] == 5'd0))
        else $error("illegal verdict code or padding");

endmodule

bind swipe_digit_code_lock_top sdcl_checker u_sdcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
